// ----- rtl/lvpt_pkg.sv -----
// Shared types and constants for the load value prediction table.
`default_nettype none
package lvpt_pkg;

  localparam int unsigned PC_W    = 64;
  localparam int unsigned TID_W   = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP     = 2'd0,
    KIND_UPDATE     = 2'd1,
    KIND_INVALIDATE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic look_rd;   // read the indexed entry for a lookup
    logic upd_wr;    // write the indexed entry for an update
    logic clr_wr;    // clear one valid bit of the sweep and advance
    logic rsp_load;  // load the response register from the read data
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // the sweep is at its last entry
    logic rsp_valid;  // the response register holds a beat
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/lvpt_req_if.sv -----
// Request channel: valid/ready handshake carrying one table operation.
`default_nettype none
interface lvpt_req_if;
  logic                            valid;
  logic                            ready;
  lvpt_pkg::kind_e                 kind;
  logic [lvpt_pkg::PC_W-1:0]       program_counter;
  logic [lvpt_pkg::TID_W-1:0]      thread_id;
  logic [lvpt_pkg::VALUE_W-1:0]    load_value;

  modport source (output valid, kind, program_counter, thread_id, load_value,
                  input ready);
  modport sink   (input valid, kind, program_counter, thread_id, load_value,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/lvpt_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one lookup result.
`default_nettype none
interface lvpt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lvpt_pkg::VALUE_W-1:0]    predicted_value;

  modport source (output valid, hit, predicted_value, input ready);
  modport sink   (input valid, hit, predicted_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/lvpt_ctrl.sv -----
// Controller state machine: sequences lookups, updates and valid-bit sweeps.
`default_nettype none
module lvpt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire lvpt_pkg::kind_e   req_kind_i,
  output logic                   req_ready_o,
  input  wire logic              rsp_ready_i,
  input  wire lvpt_pkg::status_t sts_i,
  output lvpt_pkg::cmd_t         cmd_o
);

  lvpt_pkg::state_e state_q, state_d;
  logic             accept;

  always_comb begin
    unique case (state_q)
      lvpt_pkg::ST_IDLE: req_ready_o = !sts_i.rsp_valid || rsp_ready_i;
      default:           req_ready_o = 1'b0;
    endcase
  end

  assign accept = req_valid_i && req_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lvpt_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = lvpt_pkg::ST_IDLE;
        end
      end
      lvpt_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_kind_i)
            lvpt_pkg::KIND_LOOKUP:     state_d = lvpt_pkg::ST_LOOKUP;
            lvpt_pkg::KIND_INVALIDATE: state_d = lvpt_pkg::ST_CLEAR;
            default:                   state_d = lvpt_pkg::ST_IDLE;
          endcase
        end
      end
      lvpt_pkg::ST_LOOKUP: state_d = lvpt_pkg::ST_IDLE;
      default:             state_d = lvpt_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      lvpt_pkg::ST_CLEAR: cmd_o.clr_wr = 1'b1;
      lvpt_pkg::ST_IDLE: begin
        cmd_o.look_rd = accept && (req_kind_i == lvpt_pkg::KIND_LOOKUP);
        cmd_o.upd_wr  = accept && (req_kind_i == lvpt_pkg::KIND_UPDATE);
      end
      lvpt_pkg::ST_LOOKUP: cmd_o.rsp_load = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lvpt_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lvpt_dp.sv -----
// Datapath: entry memories, index and tag logic, sweep counter and response register.
`default_nettype none
module lvpt_dp #(
  parameter int unsigned ENTRIES = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lvpt_pkg::cmd_t                 cmd_i,
  output lvpt_pkg::status_t                   sts_o,
  input  wire logic [lvpt_pkg::PC_W-1:0]      req_pc_i,
  input  wire logic [lvpt_pkg::TID_W-1:0]     req_tid_i,
  input  wire logic [lvpt_pkg::VALUE_W-1:0]   req_value_i,
  input  wire logic                           rsp_ready_i,
  output logic                                rsp_valid_o,
  output logic                                rsp_hit_o,
  output logic [lvpt_pkg::VALUE_W-1:0]        rsp_value_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned TAG_W = lvpt_pkg::PC_W - IDX_W - 1;

  logic                          valid_mem [ENTRIES];
  logic [TAG_W-1:0]              tag_mem   [ENTRIES];
  logic [lvpt_pkg::TID_W-1:0]    thr_mem   [ENTRIES];
  logic [lvpt_pkg::VALUE_W-1:0]  val_mem   [ENTRIES];

  logic [IDX_W-1:0]              idx;
  logic [TAG_W-1:0]              tag;
  logic [IDX_W-1:0]              clr_cnt_q, clr_cnt_d;

  logic                          rd_valid_q;
  logic [TAG_W-1:0]              rd_tag_q, req_tag_q;
  logic [lvpt_pkg::TID_W-1:0]    rd_thr_q, req_thr_q;
  logic [lvpt_pkg::VALUE_W-1:0]  rd_val_q;
  logic                          hit;

  logic                          rsp_valid_q, rsp_valid_d;
  logic                          rsp_hit_q;
  logic [lvpt_pkg::VALUE_W-1:0]  rsp_value_q;

  // Index folds the thread into the halfword address; the tag is what lies above it.
  assign idx = IDX_W'((req_pc_i >> 1) ^ lvpt_pkg::PC_W'(req_tid_i));
  assign tag = req_pc_i[lvpt_pkg::PC_W-1:IDX_W+1];

  // Valid bits: cleared by the sweep, set by an update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      valid_mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.upd_wr) begin
      valid_mem[idx] <= 1'b1;
    end
    if (cmd_i.look_rd) begin
      rd_valid_q <= valid_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_wr) begin
      tag_mem[idx] <= tag;
      thr_mem[idx] <= req_tid_i;
      val_mem[idx] <= req_value_i;
    end
    if (cmd_i.look_rd) begin
      rd_tag_q  <= tag_mem[idx];
      rd_thr_q  <= thr_mem[idx];
      rd_val_q  <= val_mem[idx];
      req_tag_q <= tag;
      req_thr_q <= req_tid_i;
    end
  end

  // The sweep counter wraps back to zero after the last entry.
  assign clr_cnt_d = cmd_i.clr_wr ? clr_cnt_q + IDX_W'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign hit = rd_valid_q && (rd_thr_q == req_thr_q) && (rd_tag_q == req_tag_q);

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_hit_q   <= hit;
      rsp_value_q <= hit ? rd_val_q : '0;
    end
  end

  assign sts_o.clr_last  = (clr_cnt_q == IDX_W'(ENTRIES - 1));
  assign sts_o.rsp_valid = rsp_valid_q;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_hit_o   = rsp_hit_q;
  assign rsp_value_o = rsp_value_q;

endmodule
`default_nettype wire

// ----- rtl/load_value_prediction_table_unit.sv -----
// Top level of the load value prediction table: controller plus datapath.
// An update is written as it is accepted; a lookup reads its entry into
// registers, and the LOOKUP state then loads the result into an output
// register, so a new beat is taken while it waits if the sink drains it.
// An invalidate blocks the input while the CLEAR state sweeps the valid memory.
// After reset the same sweep runs before the first beat.
`default_nettype none
module load_value_prediction_table_unit #(
  parameter int unsigned ENTRIES = 256
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lvpt_req_if.sink    req_i,
  lvpt_rsp_if.source  rsp_o
);

  lvpt_pkg::cmd_t    cmd;
  lvpt_pkg::status_t sts;

  lvpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lvpt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_pc_i    (req_i.program_counter),
    .req_tid_i   (req_i.thread_id),
    .req_value_i (req_i.load_value),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_hit_o   (rsp_o.hit),
    .rsp_value_o (rsp_o.predicted_value)
  );

endmodule
`default_nettype wire

// ----- tb/sv/lvpt_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the load value prediction table: mirrors the table and checks each lookup beat.
module lvpt_checker #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lvpt_req_if         req_i,
  lvpt_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  typedef struct {
    logic                         hit;
    logic [lvpt_pkg::VALUE_W-1:0] value;
  } lookup_result_t;

  logic                         shadow_valid  [ENTRIES];
  logic [lvpt_pkg::PC_W-1:0]    shadow_tag    [ENTRIES];
  logic [lvpt_pkg::TID_W-1:0]   shadow_thread [ENTRIES];
  logic [lvpt_pkg::VALUE_W-1:0] shadow_value  [ENTRIES];

  lookup_result_t lookup_results_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("%0t lvpt_checker: %s", $realtime, msg);
  endtask

  function automatic int unsigned slot_of(input logic [lvpt_pkg::PC_W-1:0] pc,
                                          input logic [lvpt_pkg::TID_W-1:0] tid);
    return int'(((pc >> 1) ^ lvpt_pkg::PC_W'(tid)) & lvpt_pkg::PC_W'(ENTRIES - 1));
  endfunction

  function automatic logic [lvpt_pkg::PC_W-1:0] tag_of(input logic [lvpt_pkg::PC_W-1:0] pc);
    return pc >> (IDX_W + 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    int unsigned    slot;
    if (!rst_ni) begin
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      lookup_results_q.delete();
    end else begin
      // Results are retired before the request of the same edge is folded in;
      // a lookup can never answer on the edge that accepts it.
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (lookup_results_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no lookup waiting: hit=%b value=%h",
                                    rsp_i.hit, rsp_i.predicted_value));
        end else begin
          want = lookup_results_q.pop_front();
          if (rsp_i.hit !== want.hit)
            report_mismatch($sformatf("hit: got %b, want %b", rsp_i.hit, want.hit));
          if (rsp_i.predicted_value !== want.value)
            report_mismatch($sformatf("predicted_value: got %h, want %h",
                                      rsp_i.predicted_value, want.value));
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        slot = slot_of(req_i.program_counter, req_i.thread_id);
        case (req_i.kind)
          lvpt_pkg::KIND_LOOKUP: begin
            want.hit = shadow_valid[slot] &&
                       shadow_thread[slot] == req_i.thread_id &&
                       shadow_tag[slot] == tag_of(req_i.program_counter);
            want.value = want.hit ? shadow_value[slot] : '0;
            lookup_results_q.push_back(want);
          end
          lvpt_pkg::KIND_UPDATE: begin
            shadow_tag[slot]    = tag_of(req_i.program_counter);
            shadow_thread[slot] = req_i.thread_id;
            shadow_value[slot]  = req_i.load_value;
            shadow_valid[slot]  = 1'b1;
          end
          lvpt_pkg::KIND_INVALIDATE: begin
            // Only the valid bits go; the stored contents stay.
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
          end
          default: ;
        endcase
      end
    end
    pending_o = lookup_results_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives table operations, throttles the response side and reports the verdict.
module tb;

  localparam int unsigned ENTRIES      = 256;
  localparam int unsigned IDX_W        = $clog2(ENTRIES);
  localparam int unsigned PC_W         = lvpt_pkg::PC_W;
  localparam int unsigned TID_W        = lvpt_pkg::TID_W;
  localparam int unsigned VALUE_W      = lvpt_pkg::VALUE_W;
  localparam int unsigned RANDOM_OPS   = 600;
  localparam int unsigned STALL_AT     = 500;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 64;
  localparam int unsigned RECENT_MAX   = 16;
  localparam logic [PC_W-1:0] ALL_ONES = '1;
  // The one kind code that the block ignores.
  localparam lvpt_pkg::kind_e KIND_UNUSED = lvpt_pkg::kind_e'(2'd3);

  typedef struct packed {
    logic [PC_W-1:0]  pc;
    logic [TID_W-1:0] tid;
  } site_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned beats_sent;
  bit          send_calm;
  bit          stall_done;
  site_t       recent_sites_q[$];

  lvpt_req_if req_if ();
  lvpt_rsp_if rsp_if ();

  load_value_prediction_table_unit #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  lvpt_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("** load_value_prediction_table_unit: FAILED **");
    $finish;
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Rewrites the index bits of pc so that (pc, tid) lands on the given slot.
  function automatic logic [PC_W-1:0] pc_at_slot(input logic [PC_W-1:0] pc,
                                                  input logic [TID_W-1:0] tid,
                                                  input int unsigned slot);
    logic [PC_W-1:0] moved;
    moved = pc;
    moved[IDX_W:1] = IDX_W'(slot) ^ IDX_W'(tid);
    return moved;
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(input lvpt_pkg::kind_e kind, input logic [PC_W-1:0] pc,
                         input logic [TID_W-1:0] tid, input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.kind            <= kind;
    req_if.program_counter <= pc;
    req_if.thread_id       <= tid;
    req_if.load_value      <= value;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic remember_site(input site_t site);
    recent_sites_q.push_back(site);
    if (recent_sites_q.size() > RECENT_MAX) void'(recent_sites_q.pop_front());
  endtask

  // Response side: random ready with short and long gaps, calm stretches,
  // and one long hold-off while requests keep coming.
  initial begin
    int unsigned low_left;
    int unsigned cycle;
    rsp_if.ready <= 1'b0;
    low_left = 0;
    cycle    = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      cycle++;
      if (!stall_done && beats_sent >= STALL_AT) begin
        stall_done = 1'b1;
        rsp_if.ready <= 1'b0;
        for (int unsigned c = 1; c < STALL_CYCLES; c++) @(negedge clk_i);
      end else if (low_left != 0) begin
        rsp_if.ready <= 1'b0;
        low_left--;
      end else if (((cycle / 300) % 4) != 3 && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        low_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    site_t       site;
    site_t       probe;
    int unsigned r;
    int unsigned ops;
    logic [TID_W-1:0] other_tid;

    rst_ni                 = 1'b0;
    beats_sent             = 0;
    send_calm              = 1'b0;
    stall_done             = 1'b0;
    req_if.valid           <= 1'b0;
    req_if.kind            <= lvpt_pkg::KIND_LOOKUP;
    req_if.program_counter <= '0;
    req_if.thread_id       <= '0;
    req_if.load_value      <= '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Give every entry defined contents, then drop them all.
    for (int unsigned slot = 0; slot < ENTRIES; slot++) begin
      site.tid = TID_W'($urandom);
      site.pc  = pc_at_slot(random_word(), site.tid, slot);
      send_op(lvpt_pkg::KIND_UPDATE, site.pc, site.tid, random_word());
    end
    send_op(lvpt_pkg::KIND_INVALIDATE, random_word(), TID_W'($urandom), random_word());

    // Directed: misses on invalid, tag and thread; extremes; ignored kind; re-use after clear.
    send_op(lvpt_pkg::KIND_LOOKUP, '0, 3'd0, random_word());
    send_op(lvpt_pkg::KIND_UPDATE, '0, 3'd0, ALL_ONES);
    send_op(lvpt_pkg::KIND_LOOKUP, '0, 3'd0, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, PC_W'(1) << (IDX_W + 1), 3'd0, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, PC_W'(2), 3'd1, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, PC_W'(1), 3'd0, '0);
    send_op(lvpt_pkg::KIND_UPDATE, ALL_ONES, 3'd7, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, ALL_ONES, 3'd7, ALL_ONES);
    send_op(lvpt_pkg::KIND_UPDATE, ALL_ONES >> 1, 3'd7, 64'h5555_5555_5555_5555);
    send_op(lvpt_pkg::KIND_LOOKUP, ALL_ONES, 3'd7, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, ALL_ONES >> 1, 3'd7, '0);
    send_op(KIND_UNUSED, '0, 3'd0, random_word());
    send_op(lvpt_pkg::KIND_LOOKUP, '0, 3'd0, '0);
    send_op(lvpt_pkg::KIND_INVALIDATE, ALL_ONES, 3'd7, ALL_ONES);
    send_op(lvpt_pkg::KIND_LOOKUP, '0, 3'd0, '0);
    send_op(lvpt_pkg::KIND_LOOKUP, ALL_ONES >> 1, 3'd7, '0);
    send_op(lvpt_pkg::KIND_UPDATE, '0, 3'd0, 64'h8000_0000_0000_0001);
    send_op(lvpt_pkg::KIND_LOOKUP, '0, 3'd0, '0);
    send_op(lvpt_pkg::KIND_UPDATE, ALL_ONES, 3'd0, ALL_ONES);
    send_op(lvpt_pkg::KIND_LOOKUP, ALL_ONES, 3'd0, '0);

    // Random: lookups mostly aim at recently written sites or their near misses.
    ops = 0;
    while (ops < RANDOM_OPS) begin
      send_calm = ((ops / 100) % 3) == 2;
      r = $urandom_range(0, 99);
      if (r < 38) begin
        if (recent_sites_q.size() != 0 && $urandom_range(0, 1) == 1) begin
          site = recent_sites_q[$urandom_range(0, recent_sites_q.size() - 1)];
        end else begin
          site.pc  = random_word();
          site.tid = TID_W'($urandom);
        end
        send_op(lvpt_pkg::KIND_UPDATE, site.pc, site.tid, random_word());
        remember_site(site);
        ops++;
      end else if (r < 95) begin
        r = $urandom_range(0, 99);
        if (recent_sites_q.size() == 0 || r >= 85) begin
          probe.pc  = random_word();
          probe.tid = TID_W'($urandom);
        end else begin
          probe = recent_sites_q[$urandom_range(0, recent_sites_q.size() - 1)];
          if (r >= 75) begin
            // Same slot, another thread.
            other_tid = probe.tid ^ TID_W'($urandom_range(1, 7));
            probe.pc  = pc_at_slot(probe.pc, other_tid,
                                   32'(probe.pc[IDX_W:1] ^ IDX_W'(probe.tid)));
            probe.tid = other_tid;
          end else if (r >= 60) begin
            // Same slot and thread, another tag.
            probe.pc = probe.pc ^ (PC_W'(1) << $urandom_range(IDX_W + 1, PC_W - 1));
          end
        end
        send_op(lvpt_pkg::KIND_LOOKUP, probe.pc, probe.tid, random_word());
        ops++;
      end else if (r < 97) begin
        send_op(lvpt_pkg::KIND_INVALIDATE, random_word(), TID_W'($urandom), random_word());
        ops++;
      end else begin
        send_op(KIND_UNUSED, random_word(), TID_W'($urandom), random_word());
      end
    end

    req_if.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** load_value_prediction_table_unit: PASSED **");
    end else begin
      $display("** load_value_prediction_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lvpt_pkg.sv
rtl/lvpt_req_if.sv
rtl/lvpt_rsp_if.sv
rtl/lvpt_ctrl.sv
rtl/lvpt_dp.sv
rtl/load_value_prediction_table_unit.sv
tb/sv/lvpt_checker.sv
tb/sv/tb.sv
